// ===== design/wfe_pkg.sv =====
package wfe_pkg;

	localparam int MaxLineWidth = 1024;
	localparam int MaxWindow    = 5;
	localparam int StoreLines   = MaxWindow - 1;
	localparam int WinTaps      = MaxWindow * MaxWindow;
	localparam int ColW         = $clog2(MaxLineWidth);
	localparam int LwW          = 11;
	localparam int RowW         = 12;
	localparam int AccW         = 20;
	localparam int DivW         = 12;
	localparam int CfgW         = 63;
	localparam int CfgIdxW      = 3;
	localparam int SortTaps     = 32;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] RegWindowSize   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegFilterMethod = 3'd1;
	localparam logic [CfgIdxW-1:0] RegDivisor      = 3'd2;
	localparam logic [CfgIdxW-1:0] RegClampOutput  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegLineWidth    = 3'd4;
	localparam logic [CfgIdxW-1:0] RegCoeffsLow    = 3'd5;
	localparam logic [CfgIdxW-1:0] RegCoeffsMid    = 3'd6;
	localparam logic [CfgIdxW-1:0] RegCoeffsHigh   = 3'd7;

	// Filter method codes.
	localparam logic [2:0] MethCopy  = 3'd0;
	localparam logic [2:0] MethConv  = 3'd1;
	localparam logic [2:0] MethAvg   = 3'd2;
	localparam logic [2:0] MethMed   = 3'd3;
	localparam logic [2:0] MethDil   = 3'd4;
	localparam logic [2:0] MethEro   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ACC,
		ST_SORT,
		ST_DIV,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;      // accept a pixel: read line store, shift window
		logic load;      // window ready: latch taps, clear accumulators
		logic acc_step;  // one tap into the accumulators
		logic sort_step; // one odd-even transposition pass
		logic div_start;
		logic div_step;
		logic finish;    // form the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit;      // the accepted pixel completes an interior window
		logic acc_last;
		logic sort_last;
		logic div_last;
		logic need_div;
		logic need_sort;
	} sts_t;

	// Signed 7-bit coefficient k of the three coefficient registers.
	function automatic logic signed [6:0] coeff_at(input logic [CfgIdxW+2:0] k,
		input logic [CfgW-1:0] lo, input logic [CfgW-1:0] mid,
		input logic [CfgW-1:0] hi);
		logic [CfgW-1:0] r;
		logic [3:0] sub;
		begin
			r = 'd0;
			sub = 4'd0;
			if (k < 6'd9) begin
				r = lo;
				sub = k[3:0];
			end else if (k < 6'd18) begin
				r = mid;
				sub = 4'(k - 6'd9);
			end else if (k < 6'd25) begin
				r = hi;
				sub = 4'(k - 6'd18);
			end
			coeff_at = r[7*sub +: 7];
		end
	endfunction

endpackage

// ===== design/window_filter_engine_core.sv =====
// Sliding-window gray image filter, 3x3 or 5x5.
// Input channel: pixel and frame_start, qualified by in_valid; the block
// drives in_stall. A transaction happens when in_valid is high and in_stall low.
// Output channel: filtered_value and row_end with out_valid; the receiver
// drives out_stall. One result per interior window position.
// Configuration: write cfg_we with cfg_index and cfg_data, only while idle.
// A pixel that gives no result is taken and shifted into the window. One that
// completes an interior window then runs the accumulate loop, one step per tap
// (9 or 25), then the bit-serial divider on convolution and average; median
// takes one sort pass per tap instead of the accumulate loop. The output
// register holds the result, so the next pixel is taken while it waits.
// Reset clears the position counters, the window and the configuration to
// defaults; the line store RAM is not cleared. A stalled receiver holds the
// result and the block stops before writing a second one.
module window_filter_engine_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       pixel,
	input  logic                             frame_start,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [wfe_pkg::AccW-1:0]  filtered_value,
	output logic                             row_end,
	input  logic                             cfg_we,
	input  logic [wfe_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [wfe_pkg::CfgW-1:0]         cfg_data
);
	import wfe_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [2:0]      window_size_q, filter_method_q;
	logic [DivW-1:0] divisor_q;
	logic            clamp_q;
	logic [LwW-1:0]  line_width_q;
	logic [CfgW-1:0] coeffs_low_q, coeffs_mid_q, coeffs_high_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= 3'd3;
			filter_method_q <= MethCopy;
			divisor_q <= DivW'(1);
			clamp_q <= 1'b0;
			line_width_q <= LwW'(640);
			coeffs_low_q <= '0;
			coeffs_mid_q <= '0;
			coeffs_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegWindowSize:   window_size_q <= cfg_data[2:0];
				RegFilterMethod: filter_method_q <= cfg_data[2:0];
				RegDivisor:      divisor_q <= cfg_data[DivW-1:0];
				RegClampOutput:  clamp_q <= cfg_data[0];
				RegLineWidth:    line_width_q <= cfg_data[LwW-1:0];
				RegCoeffsLow:    coeffs_low_q <= cfg_data;
				RegCoeffsMid:    coeffs_mid_q <= cfg_data;
				RegCoeffsHigh:   coeffs_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wfe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (in_valid),
		.stall      (in_stall),
		.sts        (sts),
		.cmd        (cmd),
		.res_valid_q(out_valid),
		.res_stall  (out_stall)
	);

	wfe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.window_size  (window_size_q),
		.filter_method(filter_method_q),
		.divisor      (divisor_q),
		.clamp_output (clamp_q),
		.line_width   (line_width_q),
		.coeffs_low   (coeffs_low_q),
		.coeffs_mid   (coeffs_mid_q),
		.coeffs_high  (coeffs_high_q),
		.res_value_q  (filtered_value),
		.res_row_end_q(row_end)
	);
endmodule

// ===== design/wfe_ram.sv =====
module wfe_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/wfe_ctrl.sv =====
module wfe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	output logic           stall,
	input  wfe_pkg::sts_t  sts,
	output wfe_pkg::cmd_t  cmd,
	output logic           res_valid_q,
	input  logic           res_stall
);
	import wfe_pkg::*;

	state_t state_q, state_d;
	logic res_set;

	// State register and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		res_set = 1'b0;
		stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				stall = 1'b0;
				if (valid) begin
					cmd.take = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.emit) begin
					cmd.load = 1'b1;
					if (sts.need_sort) begin
						state_d = ST_SORT;
					end else begin
						state_d = ST_ACC;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ACC: begin
				cmd.acc_step = 1'b1;
				if (sts.acc_last) begin
					if (sts.need_div) begin
						cmd.div_start = 1'b1;
						state_d = ST_DIV;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SORT: begin
				cmd.sort_step = 1'b1;
				if (sts.sort_last) begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || !res_stall) begin
					cmd.finish = 1'b1;
					res_set = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |=> res_valid_q)
		else $error("result dropped while stalled");
	ast_single_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> !cmd.take)
		else $error("two pixels taken back to back");
	ast_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(res_valid_q && res_stall))
		else $error("result overwritten");
endmodule

// ===== design/wfe_dp.sv =====
module wfe_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wfe_pkg::cmd_t              cmd,
	output wfe_pkg::sts_t              sts,
	input  logic [7:0]                 pixel,
	input  logic                       frame_start,
	input  logic [2:0]                 window_size,
	input  logic [2:0]                 filter_method,
	input  logic [wfe_pkg::DivW-1:0]   divisor,
	input  logic                       clamp_output,
	input  logic [wfe_pkg::LwW-1:0]    line_width,
	input  logic [wfe_pkg::CfgW-1:0]   coeffs_low,
	input  logic [wfe_pkg::CfgW-1:0]   coeffs_mid,
	input  logic [wfe_pkg::CfgW-1:0]   coeffs_high,
	output logic signed [wfe_pkg::AccW-1:0] res_value_q,
	output logic                       res_row_end_q
);
	import wfe_pkg::*;

	localparam int LineAw = $clog2(MaxLineWidth);
	localparam int TapW   = $clog2(WinTaps + 1);
	localparam int DivCw  = $clog2(AccW + 1);

	logic [ColW-1:0]  col_q, col_s1;
	logic [RowW-1:0]  row_q, row_s1;
	logic [7:0]       pix_s1;
	logic             wrap_s1;
	logic             take_s1;
	logic [7:0]       win_q [MaxWindow][MaxWindow];
	logic [7:0]       lb_rd [StoreLines];
	logic [2:0]       n;
	logic [ColW-1:0]  w_m1;
	logic [ColW-1:0]  col_eff;
	logic [7:0]       tap_q [WinTaps];
	logic [7:0]       srt_q [SortTaps];
	logic [TapW-1:0]  cnt_q, ntaps;
	logic signed [AccW-1:0] acc_q;
	logic [7:0]       mx_q, mn_q;
	logic [AccW-1:0]  dmag_q, rem_q;
	logic             dneg_q;
	logic [DivCw-1:0] dcnt_q;
	logic [DivW-1:0]  dv;
	logic             par_q;
	logic [10:0]      w_eff;

	// Effective window edge and line width.
	// A window size of zero never completes a window, so it gives no results.
	always_comb begin
		n = window_size;
		if (n > 3'(MaxWindow)) n = 3'(MaxWindow);
		if (!n[0] && n != 3'd0) n = n - 3'd1;
		if (n < 3'd3) n = 3'd3;
		w_eff = line_width;
		if (w_eff < 11'd1) w_eff = 11'd1;
		if (w_eff > 11'(MaxLineWidth)) w_eff = 11'(MaxLineWidth);
		w_m1 = ColW'(w_eff - 11'd1);
		col_eff = frame_start ? '0 : col_q;
		dv = (divisor == '0) ? DivW'(1) : divisor;
		ntaps = TapW'(n) * TapW'(n);
	end

	// Line store: one RAM per stored line, read while the pixel is taken.
	for (genvar g = 0; g < StoreLines; g++) begin : g_lb
		logic [7:0] wd;
		assign wd = (g == 0) ? pix_s1 : lb_rd[(g == 0) ? 0 : g - 1];
		wfe_ram #(.Width(8), .Depth(MaxLineWidth)) u_ram (
			.clk  (clk),
			.we   (take_s1),
			.waddr(col_s1[LineAw-1:0]),
			.wdata(wd),
			.raddr(col_eff[LineAw-1:0]),
			.rdata(lb_rd[g])
		);
	end

	// Position counters and the pixel latched for the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			take_s1 <= 1'b0;
		end else begin
			take_s1 <= cmd.take;
			if (cmd.take) begin
				if (col_eff >= w_m1) begin
					col_q <= '0;
					if ((frame_start ? '0 : row_q) < RowW'(4095)) begin
						row_q <= (frame_start ? '0 : row_q) + RowW'(1);
					end else begin
						row_q <= row_q;
					end
				end else begin
					col_q <= col_eff + ColW'(1);
					if (frame_start) row_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pix_s1 <= pixel;
			col_s1 <= col_eff;
			row_s1 <= frame_start ? '0 : row_q;
			wrap_s1 <= col_eff >= w_m1;
		end
	end

	// Window shift in the cycle after the take, when the line reads arrive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MaxWindow; r++)
				for (int c = 0; c < MaxWindow; c++)
					win_q[r][c] <= '0;
		end else if (take_s1) begin
			for (int r = 0; r < MaxWindow; r++)
				for (int c = 0; c + 1 < MaxWindow; c++)
					win_q[r][c] <= win_q[r][c+1];
			for (int r = 0; r + 1 < MaxWindow; r++)
				win_q[r][MaxWindow-1] <= lb_rd[MaxWindow - 2 - r];
			win_q[MaxWindow-1][MaxWindow-1] <= pix_s1;
		end
	end

	// Emission test uses the position of the taken pixel.
	always_comb begin
		sts.emit = (window_size != 3'd0) && (row_s1 >= RowW'(n - 3'd1)) &&
			(col_s1 >= ColW'(n - 3'd1));
		sts.need_sort = (filter_method == MethMed);
		sts.need_div = (filter_method == MethConv) || (filter_method == MethAvg);
		sts.acc_last = (cnt_q == ntaps - TapW'(1));
		sts.sort_last = (cnt_q == ntaps - TapW'(1));
		sts.div_last = (dcnt_q == DivCw'(1));
	end

	// Taps of the effective window, row-major, latched after the shift.
	// The shift happens at the same edge as load, so load uses the new column.
	logic [7:0] next_win [MaxWindow][MaxWindow];
	always_comb begin
		for (int r = 0; r < MaxWindow; r++)
			for (int c = 0; c + 1 < MaxWindow; c++)
				next_win[r][c] = win_q[r][c+1];
		for (int r = 0; r + 1 < MaxWindow; r++)
			next_win[r][MaxWindow-1] = lb_rd[MaxWindow - 2 - r];
		next_win[MaxWindow-1][MaxWindow-1] = pix_s1;
	end

	// Effective window in row-major order; unused sort slots hold the maximum.
	logic [7:0] sel_tap [SortTaps];
	always_comb begin
		for (int k = 0; k < SortTaps; k++)
			sel_tap[k] = 8'hFF;
		for (int r = 0; r < MaxWindow; r++)
			for (int c = 0; c < MaxWindow; c++)
				if (r < 32'(n) && c < 32'(n))
					sel_tap[r*32'(n) + c] = next_win[MaxWindow - 32'(n) + r]
						[MaxWindow - 32'(n) + c];
	end

	logic [7:0] cur_tap;
	logic signed [6:0] cur_coef;
	assign cur_tap = tap_q[cnt_q[4:0]];
	assign cur_coef = coeff_at(6'(cnt_q), coeffs_low, coeffs_mid, coeffs_high);

	logic signed [AccW-1:0] prod;
	assign prod = AccW'($signed({1'b0, cur_tap}) * cur_coef);

	// Running sum including the current tap; the divider starts from it.
	logic signed [AccW-1:0] acc_add;
	logic signed [AccW-1:0] acc_fin;
	assign acc_add = (filter_method == MethConv) ? prod : $signed({12'd0, cur_tap});
	assign acc_fin = acc_q + acc_add;

	logic [AccW-1:0] rem_sh;
	assign rem_sh = {rem_q[AccW-2:0], dmag_q[AccW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < WinTaps; k++)
				tap_q[k] <= sel_tap[k];
			for (int k = 0; k < SortTaps; k++)
				srt_q[k] <= sel_tap[k];
			cnt_q <= '0;
			acc_q <= '0;
			mx_q <= 8'd0;
			mn_q <= 8'd255;
			par_q <= 1'b0;
		end
		// One tap per cycle into sum, max and min.
		if (cmd.acc_step) begin
			cnt_q <= cnt_q + TapW'(1);
			acc_q <= acc_fin;
			if (cur_tap > mx_q) mx_q <= cur_tap;
			if (cur_tap < mn_q) mn_q <= cur_tap;
		end
		// Odd-even transposition sort, one pass per cycle.
		if (cmd.sort_step) begin
			cnt_q <= cnt_q + TapW'(1);
			par_q <= !par_q;
			for (int k = 0; k + 1 < SortTaps; k++) begin
				if ((k % 2) == (par_q ? 1 : 0)) begin
					if (srt_q[k] > srt_q[k+1]) begin
						srt_q[k] <= srt_q[k+1];
						srt_q[k+1] <= srt_q[k];
					end
				end
			end
		end
		// Restoring division of the magnitude, one bit per cycle.
		if (cmd.div_start) begin
			dneg_q <= acc_fin[AccW-1];
			dmag_q <= acc_fin[AccW-1] ? AccW'(-acc_fin) : AccW'(acc_fin);
			rem_q <= '0;
			dcnt_q <= DivCw'(AccW);
		end
		if (cmd.div_step) begin
			dcnt_q <= dcnt_q - DivCw'(1);
			if (rem_sh >= AccW'(dv)) begin
				rem_q <= rem_sh - AccW'(dv);
				dmag_q <= {dmag_q[AccW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dmag_q <= {dmag_q[AccW-2:0], 1'b0};
			end
		end
	end

	// Result register.
	logic signed [AccW-1:0] q_signed;
	assign q_signed = dneg_q ? -$signed(dmag_q) : $signed(dmag_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_row_end_q <= wrap_s1;
			case (filter_method)
				MethConv: begin
					if (clamp_output) begin
						if (q_signed < 0) res_value_q <= '0;
						else if (q_signed > 255) res_value_q <= AccW'(255);
						else res_value_q <= q_signed;
					end else begin
						res_value_q <= q_signed;
					end
				end
				MethAvg: res_value_q <= q_signed;
				MethMed: res_value_q <= AccW'(srt_q[(ntaps - TapW'(1)) >> 1]);
				MethDil: res_value_q <= AccW'(mx_q);
				MethEro: res_value_q <= AccW'(mn_q);
				default: res_value_q <= AccW'(tap_q[((ntaps - TapW'(1)) >> 1)]);
			endcase
		end
	end

	ast_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_step |-> cnt_q < ntaps)
		else $error("tap counter overran the window");
	ast_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> dcnt_q != '0)
		else $error("divider stepped past its last bit");
	ast_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> col_q <= w_m1)
		else $error("column past line end");
endmodule

// ===== test/window_filter_engine_core_test.sv =====
module window_filter_engine_core_test;
	import wfe_pkg::*;

	// Tracks the filter state and the queue of filter results still to arrive.
	class window_scoreboard;
		typedef struct {
			logic [AccW-1:0] value;
			logic            last_in_row;
		} filter_result_t;

		logic [2:0]      win_size;
		logic [2:0]      method;
		logic [DivW-1:0] divisor;
		logic            clamp;
		logic [LwW-1:0]  line_len;
		logic [CfgW-1:0] coef_lo, coef_mid, coef_hi;
		logic [7:0]      line_mem[StoreLines][MaxLineWidth];
		logic [7:0]      win[MaxWindow][MaxWindow];
		int unsigned     col_cnt;
		int unsigned     row_cnt;
		filter_result_t  due[$];
		int              errors;

		function new();
			win_size = 3;
			method = MethCopy;
			divisor = 1;
			clamp = 0;
			line_len = 640;
			coef_lo = '0;
			coef_mid = '0;
			coef_hi = '0;
			col_cnt = 0;
			row_cnt = 0;
			errors = 0;
			foreach (line_mem[i, j]) line_mem[i][j] = '0;
			foreach (win[i, j]) win[i][j] = '0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
			case (idx)
				RegWindowSize:   win_size = data[2:0];
				RegFilterMethod: method = data[2:0];
				RegDivisor:      divisor = data[DivW-1:0];
				RegClampOutput:  clamp = data[0];
				RegLineWidth:    line_len = data[LwW-1:0];
				RegCoeffsLow:    coef_lo = data;
				RegCoeffsMid:    coef_mid = data;
				RegCoeffsHigh:   coef_hi = data;
				default: ;
			endcase
		endfunction

		// Signed 7-bit weight of tap k; taps past the table weigh nothing.
		function int tap_weight(int k);
			logic [CfgW-1:0] r;
			logic [6:0] raw;
			if (k >= 25)
				return 0;
			r = (k < 9) ? coef_lo : ((k < 18) ? coef_mid : coef_hi);
			raw = 7'(r >> (7 * (k % 9)));
			return int'($signed(raw));
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Called for every accepted pixel transaction.
		function void note_pixel(logic [7:0] pix, logic fs);
			logic [7:0] column[MaxWindow];
			int vals[$];
			int w, col, n, base, d, acc, res;
			filter_result_t fr;
			if (fs) begin
				col_cnt = 0;
				row_cnt = 0;
			end
			w = line_len;
			if (w < 1) w = 1;
			if (w > MaxLineWidth) w = MaxLineWidth;
			col = col_cnt;
			if (col >= MaxLineWidth) col = MaxLineWidth - 1;

			// Line store: read the column, then push the new pixel on top.
			column[0] = pix;
			for (int k = 0; k < StoreLines; k++)
				column[k + 1] = line_mem[k][col];
			for (int k = StoreLines - 1; k > 0; k--)
				line_mem[k][col] = line_mem[k - 1][col];
			line_mem[0][col] = pix;

			// Shift the window left and insert the new column on the right.
			for (int r = 0; r < MaxWindow; r++) begin
				for (int c = 0; c < MaxWindow - 1; c++)
					win[r][c] = win[r][c + 1];
				win[r][MaxWindow - 1] = column[MaxWindow - 1 - r];
			end

			n = win_size;
			if (n > MaxWindow) n = MaxWindow;
			if (n % 2 == 0) n = n - 1;
			if (n < 3) n = 3;
			base = MaxWindow - n;

			// A window size of zero never completes a window.
			if (win_size != 0 && row_cnt >= n - 1 && col >= n - 1) begin
				d = (divisor == 0) ? 1 : int'(divisor);
				acc = 0;
				for (int r = 0; r < n; r++)
					for (int c = 0; c < n; c++)
						vals.push_back(int'(win[base + r][base + c]));
				case (method)
					MethConv: begin
						foreach (vals[k]) acc += vals[k] * tap_weight(k);
						res = acc / d;
						if (clamp)
							res = (res < 0) ? 0 : ((res > 255) ? 255 : res);
					end
					MethAvg: begin
						foreach (vals[k]) acc += vals[k];
						res = acc / d;
					end
					MethMed: begin
						vals.sort();
						res = vals[vals.size() / 2];
					end
					MethDil: begin
						res = 0;
						foreach (vals[k]) if (vals[k] > res) res = vals[k];
					end
					MethEro: begin
						res = 255;
						foreach (vals[k]) if (vals[k] < res) res = vals[k];
					end
					default: res = vals[(n / 2) * n + n / 2];
				endcase
				fr.value = res[AccW-1:0];
				fr.last_in_row = (col >= w - 1);
				due.push_back(fr);
			end

			if (col >= w - 1) begin
				col_cnt = 0;
				if (row_cnt < 4095) row_cnt++;
			end else begin
				col_cnt = col + 1;
			end
		endfunction

		// Called for every accepted result transaction.
		function void check_result(logic [AccW-1:0] value, logic last_in_row);
			filter_result_t fr;
			if (due.size() == 0) begin
				$display("%0t: unexpected result value=%0d row_end=%0b", $time,
					$signed(value), last_in_row);
				errors++;
				return;
			end
			fr = due.pop_front();
			if (fr.value !== value) begin
				$display("%0t: filtered_value expected %0d actual %0d", $time,
					$signed(fr.value), $signed(value));
				errors++;
			end
			if (fr.last_in_row !== last_in_row) begin
				$display("%0t: row_end expected %0b actual %0b", $time,
					fr.last_in_row, last_in_row);
				errors++;
			end
		endfunction
	endclass

	localparam int QuietCycles = 80;
	localparam int HangLimit   = 4000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          pixel;
	logic                frame_start;
	logic                out_valid;
	logic                out_stall;
	logic signed [AccW-1:0] filtered_value;
	logic                row_end;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgW-1:0]     cfg_data;

	window_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int pixels_sent;
	int quiet_cnt;

	window_filter_engine_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_value(filtered_value),
		.row_end(row_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Both channels are observed at the falling edge, where inputs are settled.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_pixel(pixel, frame_start);
			if (out_valid && !out_stall)
				sb.check_result(filtered_value, row_end);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cnt = 0;
			else
				quiet_cnt++;
			if (quiet_cnt >= HangLimit) begin
				$display("%0t: no transaction for %0d cycles", $time, HangLimit);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input int ws, input logic [2:0] meth, input int dv,
		input logic cl, input int lw, input logic [CfgW-1:0] lo,
		input logic [CfgW-1:0] mid, input logic [CfgW-1:0] hi);
		write_reg(RegWindowSize, CfgW'(ws));
		write_reg(RegFilterMethod, CfgW'(meth));
		write_reg(RegDivisor, CfgW'(dv));
		write_reg(RegClampOutput, CfgW'(cl));
		write_reg(RegLineWidth, CfgW'(lw));
		write_reg(RegCoeffsLow, lo);
		write_reg(RegCoeffsMid, mid);
		write_reg(RegCoeffsHigh, hi);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Valid stays high across back-to-back transactions; it drops for an idle gap and at the end of a frame.
	// The idling mix follows the number of pixels sent so far.
	task automatic send_pixel(input logic [7:0] p, input logic fs);
		logic taken;
		if (pixels_sent < 620) begin
			send_idle_pct = 14;
			recv_idle_pct = 76;
		end else if (pixels_sent < 1240) begin
			send_idle_pct = 76;
			recv_idle_pct = 14;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pixel <= p;
		frame_start <= fs;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		pixels_sent++;
	endtask

	// One frame; extremes favors 0 and 255, break_pct restarts the frame mid-stream.
	task automatic send_frame(input int count, input bit extremes, input int break_pct);
		logic [7:0] p;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(extremes ? 2 : 9))
				0: p = 8'd0;
				1: p = 8'd255;
				default: p = 8'($urandom);
			endcase
			send_pixel(p, (i == 0) || ($urandom_range(99) < break_pct));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (QuietCycles) @(posedge clk);
	endtask

	function automatic logic [CfgW-1:0] fill_coeffs(input logic [6:0] w);
		logic [CfgW-1:0] r;
		for (int k = 0; k < 9; k++) r[7*k +: 7] = w;
		return r;
	endfunction

	function automatic logic [CfgW-1:0] rand_coeffs();
		return CfgW'({$urandom, $urandom});
	endfunction

	initial begin
		int ws, dv, lw, count, rows, phase;
		logic [2:0] meth;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_left = 0;
		quiet_cnt = 0;
		pixels_sent = 0;
		send_idle_pct = 14;
		recv_idle_pct = 76;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: every method, both window sizes, weight and divisor extremes.
		configure(3, MethCopy, 1, 0, 5, '0, '0, '0);
		// Long receiver hold-off so the block backs up into its input.
		hold_left = 300;
		send_frame(15, 1, 0);
		configure(3, MethConv, 1, 0, 5, fill_coeffs(7'h40), fill_coeffs(7'h40), '0);
		send_frame(15, 1, 0);
		configure(5, MethConv, 4095, 1, 5, fill_coeffs(7'h3f), fill_coeffs(7'h3f),
			fill_coeffs(7'h3f));
		send_frame(25, 1, 0);
		configure(5, MethAvg, 25, 0, 5, '0, '0, '0);
		send_frame(25, 1, 0);
		configure(3, MethMed, 0, 0, 5, '0, '0, '0);
		send_frame(15, 1, 0);
		configure(7, MethDil, 1, 0, 6, '0, '0, '0);
		send_frame(30, 1, 0);
		configure(0, MethEro, 1, 0, 5, '0, '0, '0);
		send_frame(15, 1, 0);
		configure(4, 3'd7, 1, 1, 5, '0, '0, '0);
		send_frame(20, 1, 0);

		// Random frames with idling that changes over the run.
		phase = 0;
		while (pixels_sent < 1800) begin
			ws = $urandom_range(7);
			meth = 3'($urandom);
			case ($urandom_range(3))
				0: dv = $urandom_range(4095);
				1: dv = (ws >= 5) ? 25 : 9;
				default: dv = $urandom_range(1, 40);
			endcase
			rows = $urandom_range(5, 8);
			case ($urandom_range(19))
				0: lw = 0;
				1: lw = 1;
				2: begin
					if (pixels_sent < 600)
						lw = (phase % 2) ? 1024 : 2047;
					else
						lw = $urandom_range(13, 40);
				end
				3: lw = $urandom_range(13, 40);
				default: lw = $urandom_range(5, 12);
			endcase
			configure(ws, meth, dv, 1'($urandom_range(1)), lw, rand_coeffs(),
				rand_coeffs(), rand_coeffs());
			if (lw >= 1024)
				count = 1024 + $urandom_range(10, 40);
			else
				count = ((lw < 1) ? 1 : lw) * rows + $urandom_range(lw);
			if (count > 1850 - pixels_sent)
				count = 1850 - pixels_sent;
			// Long receiver hold-off so the block backs up into its input.
			if (phase == 3)
				hold_left = 500;
			send_frame(count, $urandom_range(3) == 0,
				($urandom_range(4) == 0) ? 3 : 0);
			phase++;
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/wfe_pkg.sv
design/wfe_ram.sv
design/wfe_ctrl.sv
design/wfe_dp.sv
design/window_filter_engine_core.sv
test/window_filter_engine_core_test.sv
